### src/vcsp_pkg.sv
`timescale 1ns / 1ps

package vcsp_pkg;

  // Saturation limits for size words and the voxel count
  localparam int MAX_DIM      = 256;
  localparam int PALETTE_SIZE = 256;
  localparam int MAX_VOXELS   = 2 ** 24;

  // Chunk ids as they sit in the little-endian shift word
  localparam logic [31:0] ID_PACK = 32'h4B43_4150;
  localparam logic [31:0] ID_SIZE = 32'h455A_4953;
  localparam logic [31:0] ID_XYZI = 32'h495A_5958;
  localparam logic [31:0] ID_RGBA = 32'h4142_4752;

  // File magic "VOX"
  localparam logic [7:0] MAGIC_0 = 8'h56;
  localparam logic [7:0] MAGIC_1 = 8'h4F;
  localparam logic [7:0] MAGIC_2 = 8'h58;

  typedef enum logic [2:0] {
    KIND_VOXEL   = 3'd0,
    KIND_PALETTE = 3'd1,
    KIND_SIZE    = 3'd2,
    KIND_BOUNDS  = 3'd3,
    KIND_DONE    = 3'd4,
    KIND_ERROR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_BAD_MAGIC   = 2'd1,
    ERR_MODEL_COUNT = 2'd2,
    ERR_TRUNCATED   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_FILE    = 2'd0,
    PH_CHUNK   = 2'd1,
    PH_CONTENT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CK_UNKNOWN = 3'd0,
    CK_PACK    = 3'd1,
    CK_SIZE    = 3'd2,
    CK_XYZI    = 3'd3,
    CK_RGBA    = 3'd4
  } chunk_t;

  typedef struct packed {
    kind_t       kind;
    logic [24:0] item_index;
    logic [7:0]  coord_x;
    logic [7:0]  coord_y;
    logic [7:0]  coord_z;
    logic [7:0]  color_index;
    logic [31:0] rgba_word;
    logic [8:0]  extent_x;
    logic [8:0]  extent_y;
    logic [8:0]  extent_z;
    err_t        error_code;
    logic        last_result;
  } result_t;

  // Results caused by one byte, up to three
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     slot;
  } step_t;

endpackage

### src/vcsp_parse.sv
`timescale 1ns / 1ps

module vcsp_parse (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output vcsp_pkg::step_t step
);

  vcsp_pkg::phase_t phase, phase_next;
  logic [3:0]       pos, pos_next;
  logic [31:0]      word_shift, ws_next;
  vcsp_pkg::chunk_t chunk_kind, kind_next;
  logic [31:0]      remaining, rem_next;
  logic [24:0]      vox_expected, vexp_next;
  logic [24:0]      elem_index, elem_next;
  logic [7:0]       min_x, min_y, min_z, min_x_next, min_y_next, min_z_next;
  logic [7:0]       max_x, max_y, max_z, max_x_next, max_y_next, max_z_next;
  logic             finished, finished_next;
  logic [8:0]       held_x, held_y, held_x_next, held_y_next;
  logic [31:0]      shift_in;
  logic [7:0]       vx, vy, vz;

  assign shift_in = {data_byte, word_shift[31:8]};
  assign vx = shift_in[7:0];
  assign vz = shift_in[15:8];
  assign vy = shift_in[23:16];

  function automatic logic [8:0] sat_dim(input logic [31:0] w);
    if (w[31]) begin
      return '0;
    end else if (w > 32'(vcsp_pkg::MAX_DIM)) begin
      return 9'(vcsp_pkg::MAX_DIM);
    end
    return w[8:0];
  endfunction

  function automatic logic [24:0] sat_count(input logic [31:0] w);
    if (w[31]) begin
      return '0;
    end else if (w > 32'(vcsp_pkg::MAX_VOXELS)) begin
      return 25'(vcsp_pkg::MAX_VOXELS);
    end
    return w[24:0];
  endfunction

  // Offsets past 15 fold back into 12..15: keeps the word phase, stays above 11
  function automatic logic [3:0] pos_inc(input logic [3:0] p);
    return (p == 4'd15) ? 4'd12 : p + 4'd1;
  endfunction

  function automatic logic [7:0] magic(input logic [1:0] i);
    logic [7:0] m;
    unique case (i)
      2'd0:    m = vcsp_pkg::MAGIC_0;
      2'd1:    m = vcsp_pkg::MAGIC_1;
      default: m = vcsp_pkg::MAGIC_2;
    endcase
    return m;
  endfunction

  function automatic vcsp_pkg::chunk_t decode_id(input logic [31:0] id);
    vcsp_pkg::chunk_t k;
    unique case (id)
      vcsp_pkg::ID_PACK: k = vcsp_pkg::CK_PACK;
      vcsp_pkg::ID_SIZE: k = vcsp_pkg::CK_SIZE;
      vcsp_pkg::ID_XYZI: k = vcsp_pkg::CK_XYZI;
      vcsp_pkg::ID_RGBA: k = vcsp_pkg::CK_RGBA;
      default:           k = vcsp_pkg::CK_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic vcsp_pkg::result_t mk_bounds(
    input logic [24:0] idx,
    input logic [7:0] mnx, input logic [7:0] mny, input logic [7:0] mnz,
    input logic [7:0] mxx, input logic [7:0] mxy, input logic [7:0] mxz
  );
    vcsp_pkg::result_t r;
    r            = '0;
    r.kind       = vcsp_pkg::KIND_BOUNDS;
    r.item_index = idx;
    r.coord_x    = mnx;
    r.coord_y    = mny;
    r.coord_z    = mnz;
    r.extent_x   = {1'b0, mxx} + 9'd1;
    r.extent_y   = {1'b0, mxy} + 9'd1;
    r.extent_z   = {1'b0, mxz} + 9'd1;
    return r;
  endfunction

  function automatic vcsp_pkg::result_t mk_end(input vcsp_pkg::kind_t k,
                                               input vcsp_pkg::err_t e);
    vcsp_pkg::result_t r;
    r            = '0;
    r.kind       = k;
    r.error_code = e;
    return r;
  endfunction

  always_comb begin
    logic [1:0]        cnt;
    logic              word_end;
    vcsp_pkg::result_t r;

    phase_next    = phase;
    pos_next      = pos;
    ws_next       = word_shift;
    kind_next     = chunk_kind;
    rem_next      = remaining;
    vexp_next     = vox_expected;
    elem_next     = elem_index;
    min_x_next    = min_x;
    min_y_next    = min_y;
    min_z_next    = min_z;
    max_x_next    = max_x;
    max_y_next    = max_y;
    max_z_next    = max_z;
    finished_next = finished;
    held_x_next   = held_x;
    held_y_next   = held_y;
    step          = '0;
    cnt           = '0;
    word_end      = (pos[1:0] == 2'd3);
    r             = '0;

    if (!finished) begin
      if (phase == vcsp_pkg::PH_FILE) begin
        if (pos < 4'd3 && data_byte != magic(pos[1:0])) begin
          step.slot[cnt] = mk_end(vcsp_pkg::KIND_ERROR, vcsp_pkg::ERR_BAD_MAGIC);
          cnt            = cnt + 2'd1;
          finished_next  = 1'b1;
        end else if (pos == 4'd7) begin
          phase_next = vcsp_pkg::PH_CHUNK;
          pos_next   = '0;
        end else begin
          pos_next = pos + 4'd1;
        end
      end else if (phase == vcsp_pkg::PH_CHUNK && pos == 4'd0 && data_byte == 8'd0) begin
        step.slot[cnt] = mk_end(vcsp_pkg::KIND_DONE, vcsp_pkg::ERR_NONE);
        cnt            = cnt + 2'd1;
        finished_next  = 1'b1;
      end else begin
        ws_next = shift_in;
        if (phase == vcsp_pkg::PH_CHUNK) begin
          if (pos == 4'd3) begin
            kind_next  = decode_id(shift_in);
            elem_next  = '0;
            vexp_next  = '0;
            min_x_next = 8'hFF;
            min_y_next = 8'hFF;
            min_z_next = 8'hFF;
            max_x_next = '0;
            max_y_next = '0;
            max_z_next = '0;
          end else if (pos == 4'd7) begin
            rem_next = shift_in;
          end
          if (pos >= 4'd11) begin
            pos_next   = '0;
            phase_next = (remaining == 32'd0) ? vcsp_pkg::PH_CHUNK : vcsp_pkg::PH_CONTENT;
          end else begin
            pos_next = pos + 4'd1;
          end
        end else begin
          unique case (chunk_kind)
            vcsp_pkg::CK_PACK: begin
              if (pos == 4'd3 && shift_in != 32'd1) begin
                step.slot[cnt] = mk_end(vcsp_pkg::KIND_ERROR, vcsp_pkg::ERR_MODEL_COUNT);
                cnt            = cnt + 2'd1;
                finished_next  = 1'b1;
              end
            end
            vcsp_pkg::CK_SIZE: begin
              if (pos == 4'd3) begin
                held_x_next = sat_dim(shift_in);
              end else if (pos == 4'd7) begin
                held_y_next = sat_dim(shift_in);
              end else if (pos == 4'd11) begin
                r              = '0;
                r.kind         = vcsp_pkg::KIND_SIZE;
                r.extent_x     = held_x;
                r.extent_y     = held_y;
                r.extent_z     = sat_dim(shift_in);
                step.slot[cnt] = r;
                cnt            = cnt + 2'd1;
              end
            end
            vcsp_pkg::CK_XYZI: begin
              if (pos == 4'd3) begin
                vexp_next = sat_count(shift_in);
                if (vexp_next == 25'd0) begin
                  step.slot[cnt] = mk_bounds(elem_index, min_x, min_y, min_z,
                                             max_x, max_y, max_z);
                  cnt            = cnt + 2'd1;
                end
              end else if (pos > 4'd3 && word_end && elem_index < vox_expected) begin
                r              = '0;
                r.kind         = vcsp_pkg::KIND_VOXEL;
                r.item_index   = elem_index;
                r.coord_x      = vx;
                r.coord_y      = vy;
                r.coord_z      = vz;
                r.color_index  = shift_in[31:24];
                step.slot[cnt] = r;
                cnt            = cnt + 2'd1;
                min_x_next     = (vx < min_x) ? vx : min_x;
                min_y_next     = (vy < min_y) ? vy : min_y;
                min_z_next     = (vz < min_z) ? vz : min_z;
                max_x_next     = (vx > max_x) ? vx : max_x;
                max_y_next     = (vy > max_y) ? vy : max_y;
                max_z_next     = (vz > max_z) ? vz : max_z;
                elem_next      = elem_index + 25'd1;
                if (elem_next >= vox_expected) begin
                  step.slot[cnt] = mk_bounds(elem_next, min_x_next, min_y_next,
                                             min_z_next, max_x_next, max_y_next,
                                             max_z_next);
                  cnt            = cnt + 2'd1;
                end
              end
            end
            vcsp_pkg::CK_RGBA: begin
              if (word_end && elem_index < 25'(vcsp_pkg::PALETTE_SIZE)) begin
                r              = '0;
                r.kind         = vcsp_pkg::KIND_PALETTE;
                r.item_index   = elem_index;
                r.rgba_word    = shift_in;
                step.slot[cnt] = r;
                cnt            = cnt + 2'd1;
                elem_next      = elem_index + 25'd1;
              end
            end
            default: begin
            end
          endcase

          if (!finished_next) begin
            rem_next = remaining - 32'd1;
            if (remaining == 32'd1) begin
              // Short XYZI content: close the bounds over the voxels seen
              if (chunk_kind == vcsp_pkg::CK_XYZI && pos >= 4'd3 && elem_next < vexp_next) begin
                step.slot[cnt] = mk_bounds(elem_next, min_x_next, min_y_next,
                                           min_z_next, max_x_next, max_y_next,
                                           max_z_next);
                cnt            = cnt + 2'd1;
              end
              phase_next = vcsp_pkg::PH_CHUNK;
              pos_next   = '0;
            end else begin
              pos_next = pos_inc(pos);
            end
          end
        end
      end

      if (last_byte && !finished_next) begin
        if (phase_next == vcsp_pkg::PH_CHUNK && pos_next == 4'd0) begin
          step.slot[cnt] = mk_end(vcsp_pkg::KIND_DONE, vcsp_pkg::ERR_NONE);
        end else begin
          step.slot[cnt] = mk_end(vcsp_pkg::KIND_ERROR, vcsp_pkg::ERR_TRUNCATED);
        end
        cnt           = cnt + 2'd1;
        finished_next = 1'b1;
      end
    end

    step.count = cnt;
    if (cnt != 2'd0) begin
      step.slot[2'(cnt - 2'd1)].last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= vcsp_pkg::PH_FILE;
      pos          <= '0;
      word_shift   <= '0;
      chunk_kind   <= vcsp_pkg::CK_UNKNOWN;
      remaining    <= '0;
      vox_expected <= '0;
      elem_index   <= '0;
      min_x        <= 8'hFF;
      min_y        <= 8'hFF;
      min_z        <= 8'hFF;
      max_x        <= '0;
      max_y        <= '0;
      max_z        <= '0;
      finished     <= 1'b0;
      held_x       <= '0;
      held_y       <= '0;
    end else if (take) begin
      phase        <= phase_next;
      pos          <= pos_next;
      word_shift   <= ws_next;
      chunk_kind   <= kind_next;
      remaining    <= rem_next;
      vox_expected <= vexp_next;
      elem_index   <= elem_next;
      min_x        <= min_x_next;
      min_y        <= min_y_next;
      min_z        <= min_z_next;
      max_x        <= max_x_next;
      max_y        <= max_y_next;
      max_z        <= max_z_next;
      finished     <= finished_next;
      held_x       <= held_x_next;
      held_y       <= held_y_next;
    end
  end

endmodule

### src/voxel_chunk_stream_parser.sv
`timescale 1ns / 1ps

// Voxel model chunk stream parser. Feed the file one byte per transfer on the
// input channel, with last_byte set on the final byte. The parser checks the
// "VOX" header, walks chunks, and emits voxels, palette words, size and
// bounds results, then a done or error result that ends the file; later
// bytes are taken and dropped until reset. Rate: a byte is taken in any
// cycle in which the four-entry result queue holds at most one result, so a
// stream whose bytes each cause at most one result runs at one byte per
// cycle with the output ready. The single output channel moves one result per
// cycle while out_ready is high, so the results of a byte that causes two or
// three (last voxel plus bounds, plus done or error) leave one at a time.
// Parsing state updates at the transfer, which writes its results to the queue.
module voxel_chunk_stream_parser (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [24:0] item_index,
  output logic [7:0]  coord_x,
  output logic [7:0]  coord_y,
  output logic [7:0]  coord_z,
  output logic [7:0]  color_index,
  output logic [31:0] rgba_word,
  output logic [8:0]  extent_x,
  output logic [8:0]  extent_y,
  output logic [8:0]  extent_z,
  output logic [1:0]  error_code,
  output logic        last_result
);

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);
  localparam int SlotCount  = 3;

  logic                   take;
  logic                   pop;
  vcsp_pkg::step_t        step;
  vcsp_pkg::result_t      queue [QueueDepth];
  vcsp_pkg::result_t      head;
  logic [QueueAw-1:0]     wr_ptr;
  logic [QueueAw-1:0]     rd_ptr;
  logic [QueueAw:0]       count;

  // Take a byte only while the queue has room for the worst case of three
  assign in_ready  = (count <= (QueueAw + 1)'(QueueDepth - SlotCount));
  assign take      = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;

  vcsp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .step      (step)
  );

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        wr_ptr <= wr_ptr + QueueAw'(step.count);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QueueAw'(1);
      end
      count <= count + (take ? (QueueAw + 1)'(step.count) : '0)
                     - (QueueAw + 1)'(pop);
    end
  end

  // Result storage: write the results of the transferred byte in order
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < SlotCount; i++) begin
        if (2'(i) < step.count) begin
          queue[wr_ptr + QueueAw'(i)] <= step.slot[i];
        end
      end
    end
  end

  // Head of the queue drives the output fields; it holds until popped
  assign head        = queue[rd_ptr];
  assign kind        = head.kind;
  assign item_index  = head.item_index;
  assign coord_x     = head.coord_x;
  assign coord_y     = head.coord_y;
  assign coord_z     = head.coord_z;
  assign color_index = head.color_index;
  assign rgba_word   = head.rgba_word;
  assign extent_x    = head.extent_x;
  assign extent_y    = head.extent_y;
  assign extent_z    = head.extent_z;
  assign error_code  = head.error_code;
  assign last_result = head.last_result;

endmodule

### src/vcsp_checker.sv
`timescale 1ns / 1ps

module vcsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] kind,
  input logic       last_result
);

  logic is_end;

  assign is_end = (kind == vcsp_pkg::KIND_DONE) || (kind == vcsp_pkg::KIND_ERROR);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last_result))
    else $error("result changed while stalled");

  // Done or error closes the byte that caused it
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_end |-> last_result)
    else $error("end result not marked last");

  // Nothing follows the end of the file
  a_end_drains: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && is_end |=> !out_valid)
    else $error("result after end of file");

  // Input backpressure comes only from waiting results
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input held off with no result pending");

endmodule

bind voxel_chunk_stream_parser vcsp_checker u_vcsp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .kind        (kind),
  .last_result (last_result)
);

### tb/tb_voxel_chunk_stream_parser.sv
`timescale 1ns / 1ps

module tb_voxel_chunk_stream_parser;

  // Clock, reset and the ports of the parser; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [24:0] item_index;
  logic [7:0]  coord_x;
  logic [7:0]  coord_y;
  logic [7:0]  coord_z;
  logic [7:0]  color_index;
  logic [31:0] rgba_word;
  logic [8:0]  extent_x;
  logic [8:0]  extent_y;
  logic [8:0]  extent_z;
  logic [1:0]  error_code;
  logic        last_result;

  voxel_chunk_stream_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .item_index  (item_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .color_index (color_index),
    .rgba_word   (rgba_word),
    .extent_x    (extent_x),
    .extent_y    (extent_y),
    .extent_z    (extent_z),
    .error_code  (error_code),
    .last_result (last_result)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results the parser still owes us, oldest first
  vcsp_pkg::result_t expected_results[$];
  int      mismatches = 0;
  int      bytes_sent = 0;

  // Idle control for the byte source and the result sink
  bit src_steady  = 1'b0;
  bit sink_steady = 1'b0;
  int sink_hold   = 0;

  // Chunk content under construction, sent by emit_chunk
  logic [7:0] body_q[$];

  // Parser state as the predictor tracks it
  vcsp_pkg::phase_t file_phase = vcsp_pkg::PH_FILE;
  logic [31:0] hdr_pos = '0;
  logic [31:0] shift_word = '0;
  vcsp_pkg::chunk_t cur_chunk = vcsp_pkg::CK_UNKNOWN;
  logic [31:0] bytes_left = '0;
  logic [31:0] voxel_total = '0;
  logic [31:0] elem_idx = '0;
  logic [7:0]  lo_x = 8'hFF, lo_y = 8'hFF, lo_z = 8'hFF;
  logic [7:0]  hi_x = 8'h00, hi_y = 8'h00, hi_z = 8'h00;
  logic [8:0]  size_x_hold = '0;
  logic [8:0]  size_y_hold = '0;
  bit          parse_over = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Size words are signed: negative clamps to zero, large clamps to MAX_DIM
  function automatic logic [8:0] clamp_dim(logic [31:0] w);
    if (w[31]) return 9'd0;
    if (w > vcsp_pkg::MAX_DIM) return 9'(vcsp_pkg::MAX_DIM);
    return w[8:0];
  endfunction

  task automatic emit_bounds();
    vcsp_pkg::result_t r;
    r = '0;
    r.kind       = vcsp_pkg::KIND_BOUNDS;
    r.item_index = elem_idx[24:0];
    r.coord_x    = lo_x;
    r.coord_y    = lo_y;
    r.coord_z    = lo_z;
    r.extent_x   = {1'b0, hi_x} + 9'd1;
    r.extent_y   = {1'b0, hi_y} + 9'd1;
    r.extent_z   = {1'b0, hi_z} + 9'd1;
    expected_results.push_back(r);
  endtask

  // An error always ends the file
  task automatic emit_error(vcsp_pkg::err_t code);
    vcsp_pkg::result_t r;
    r = '0;
    r.kind       = vcsp_pkg::KIND_ERROR;
    r.error_code = code;
    expected_results.push_back(r);
    parse_over = 1'b1;
  endtask

  task automatic emit_done();
    vcsp_pkg::result_t r;
    r = '0;
    r.kind = vcsp_pkg::KIND_DONE;
    expected_results.push_back(r);
    parse_over = 1'b1;
  endtask

  // Advance the predicted parser by one accepted byte and queue what it causes
  task automatic parse_file_byte(input logic [7:0] b, input logic last);
    vcsp_pkg::result_t r;
    logic [31:0] o;
    logic [7:0]  vx, vy, vz;
    int          n0;
    n0 = expected_results.size();
    if (!parse_over) begin
      if (file_phase == vcsp_pkg::PH_FILE) begin
        // Only the first three header bytes are checked
        if (hdr_pos < 3 && b != ((hdr_pos == 0) ? vcsp_pkg::MAGIC_0 :
                                 (hdr_pos == 1) ? vcsp_pkg::MAGIC_1 :
                                                  vcsp_pkg::MAGIC_2)) begin
          emit_error(vcsp_pkg::ERR_BAD_MAGIC);
        end else begin
          hdr_pos++;
          if (hdr_pos >= 8) begin
            file_phase = vcsp_pkg::PH_CHUNK;
            hdr_pos    = 0;
          end
        end
      end else if (file_phase == vcsp_pkg::PH_CHUNK && hdr_pos == 0 && b == 8'h00) begin
        // Zero where a chunk id would start closes the file cleanly
        emit_done();
      end else begin
        shift_word = {b, shift_word[31:8]};
        if (file_phase == vcsp_pkg::PH_CHUNK) begin
          if (hdr_pos == 3) begin
            case (shift_word)
              vcsp_pkg::ID_PACK: cur_chunk = vcsp_pkg::CK_PACK;
              vcsp_pkg::ID_SIZE: cur_chunk = vcsp_pkg::CK_SIZE;
              vcsp_pkg::ID_XYZI: cur_chunk = vcsp_pkg::CK_XYZI;
              vcsp_pkg::ID_RGBA: cur_chunk = vcsp_pkg::CK_RGBA;
              default:           cur_chunk = vcsp_pkg::CK_UNKNOWN;
            endcase
            elem_idx    = 0;
            voxel_total = 0;
            lo_x = 8'hFF; lo_y = 8'hFF; lo_z = 8'hFF;
            hi_x = 8'h00; hi_y = 8'h00; hi_z = 8'h00;
          end else if (hdr_pos == 7) begin
            bytes_left = shift_word;
          end
          // Children size (bytes 8..11) is read and dropped
          if (hdr_pos >= 11) begin
            hdr_pos    = 0;
            file_phase = (bytes_left == 0) ? vcsp_pkg::PH_CHUNK : vcsp_pkg::PH_CONTENT;
          end else begin
            hdr_pos++;
          end
        end else begin
          o = hdr_pos;
          case (cur_chunk)
            vcsp_pkg::CK_PACK: begin
              if (o == 3 && shift_word != 32'd1) emit_error(vcsp_pkg::ERR_MODEL_COUNT);
            end
            vcsp_pkg::CK_SIZE: begin
              if (o == 3) size_x_hold = clamp_dim(shift_word);
              else if (o == 7) size_y_hold = clamp_dim(shift_word);
              else if (o == 11) begin
                r = '0;
                r.kind     = vcsp_pkg::KIND_SIZE;
                r.extent_x = size_x_hold;
                r.extent_y = size_y_hold;
                r.extent_z = clamp_dim(shift_word);
                expected_results.push_back(r);
              end
            end
            vcsp_pkg::CK_XYZI: begin
              if (o == 3) begin
                // Voxel count is signed and saturates at 2^24
                if (shift_word[31]) voxel_total = 0;
                else if (shift_word > vcsp_pkg::MAX_VOXELS) voxel_total = vcsp_pkg::MAX_VOXELS;
                else voxel_total = shift_word;
                if (voxel_total == 0) emit_bounds();
              end else if (o > 3 && o[1:0] == 2'b11 && elem_idx < voxel_total) begin
                // File order is x, depth, up, colour; report up as y
                vx = shift_word[7:0];
                vz = shift_word[15:8];
                vy = shift_word[23:16];
                r = '0;
                r.kind        = vcsp_pkg::KIND_VOXEL;
                r.item_index  = elem_idx[24:0];
                r.coord_x     = vx;
                r.coord_y     = vy;
                r.coord_z     = vz;
                r.color_index = shift_word[31:24];
                expected_results.push_back(r);
                if (vx < lo_x) lo_x = vx;
                if (vy < lo_y) lo_y = vy;
                if (vz < lo_z) lo_z = vz;
                if (vx > hi_x) hi_x = vx;
                if (vy > hi_y) hi_y = vy;
                if (vz > hi_z) hi_z = vz;
                elem_idx++;
                if (elem_idx >= voxel_total) emit_bounds();
              end
            end
            vcsp_pkg::CK_RGBA: begin
              if (o[1:0] == 2'b11 && elem_idx < vcsp_pkg::PALETTE_SIZE) begin
                r = '0;
                r.kind       = vcsp_pkg::KIND_PALETTE;
                r.item_index = elem_idx[24:0];
                r.rgba_word  = shift_word;
                expected_results.push_back(r);
                elem_idx++;
              end
            end
            default: ;
          endcase
          if (!parse_over) begin
            bytes_left--;
            if (bytes_left == 0) begin
              // Voxel content cut short after its count: bound what was seen
              if (cur_chunk == vcsp_pkg::CK_XYZI && o >= 3 && elem_idx < voxel_total)
                emit_bounds();
              file_phase = vcsp_pkg::PH_CHUNK;
              hdr_pos    = 0;
            end else begin
              hdr_pos++;
            end
          end
        end
      end
      if (last && !parse_over) begin
        if (file_phase == vcsp_pkg::PH_CHUNK && hdr_pos == 0) emit_done();
        else emit_error(vcsp_pkg::ERR_TRUNCATED);
      end
      if (expected_results.size() > n0)
        expected_results[expected_results.size() - 1].last_result = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checker: compare each output transfer, then predict from each input transfer
  // ---------------------------------------------------------------------------

  function automatic string show(vcsp_pkg::result_t r);
    return $sformatf("kind %0d idx %0d xyz %0d/%0d/%0d color %0d rgba %h ext %0d/%0d/%0d err %0d last %0b",
                     r.kind, r.item_index, r.coord_x, r.coord_y, r.coord_z, r.color_index,
                     r.rgba_word, r.extent_x, r.extent_y, r.extent_z, r.error_code,
                     r.last_result);
  endfunction

  always @(posedge clk) begin : check_results
    vcsp_pkg::result_t got;
    vcsp_pkg::result_t exp_r;
    bit      bad;
    string   why;
    if (!rst) begin
      // Output first: a result can only stem from a byte taken at an earlier edge
      if (out_valid && out_ready) begin
        got = {kind, item_index, coord_x, coord_y, coord_z, color_index, rgba_word,
               extent_x, extent_y, extent_z, error_code, last_result};
        if (expected_results.size() == 0) begin
          exp_r = '0;
          bad   = 1'b1;
          why   = "no result expected";
        end else begin
          exp_r = expected_results.pop_front();
          bad   = (got !== exp_r);
          why   = "field mismatch";
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: %s\n  expected %s\n  actual   %s",
                     $time, why, show(exp_r), show(got));
        end
      end
      if (in_valid && in_ready) parse_file_byte(data_byte, last_byte);
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls per result, plus a long hold on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int wait_cycles;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      // Long hold-off so the result queue fills and the parser stalls its input
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold) @(negedge clk);
        sink_hold = 0;
      end
      wait_cycles = sink_steady ? 0 : $urandom_range(0, 5);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------

  // Offer one byte from a falling edge and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    body_q.push_back(b);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) body_q.push_back(w[8*k +: 8]);
  endtask

  // Send a chunk header and the content in body_q; stop after byte last_at,
  // which carries the end-of-file mark (-1: send all, no mark)
  task automatic emit_chunk(input logic [31:0] id, input logic [31:0] size,
                            input logic [31:0] children, input int last_at);
    logic [95:0] hdr;
    logic [7:0]  bytes_q[$];
    hdr = {children, size, id};
    for (int k = 0; k < 12; k++) bytes_q.push_back(hdr[8*k +: 8]);
    foreach (body_q[k]) bytes_q.push_back(body_q[k]);
    body_q.delete();
    for (int k = 0; k < bytes_q.size(); k++) begin
      send_byte(bytes_q[k], k == last_at);
      if (k == last_at) break;
    end
  endtask

  // Byte with the extremes drawn often
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    v = 8'($urandom);
    case ($urandom_range(0, 5))
      0: v = 8'h00;
      1: v = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_dim();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'd0;
      1: v = vcsp_pkg::MAX_DIM;
      2: v = vcsp_pkg::MAX_DIM + $urandom_range(1, 1000);
      3: v = 32'h8000_0000 | $urandom;
      4: v = $urandom;
      default: v = $urandom_range(1, vcsp_pkg::MAX_DIM);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] random_children();
    logic [31:0] v;
    v = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    return v;
  endfunction

  // A random id that is not one of the handled ones and never opens with zero
  function automatic logic [31:0] other_id();
    logic [31:0] v;
    v = $urandom;
    if (v[7:0] == 8'h00) v[7:0] = 8'h01;
    if (v == vcsp_pkg::ID_PACK || v == vcsp_pkg::ID_SIZE ||
        v == vcsp_pkg::ID_XYZI || v == vcsp_pkg::ID_RGBA) v[31] = ~v[31];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Magic, then five unchecked header bytes at both extremes and random
  task automatic test_file_header();
    send_byte(vcsp_pkg::MAGIC_0, 1'b0);
    send_byte(vcsp_pkg::MAGIC_1, 1'b0);
    send_byte(vcsp_pkg::MAGIC_2, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    repeat (3) send_byte(8'($urandom), 1'b0);
  endtask

  // Good model count with trailing bytes; a count word cut short is not checked
  task automatic test_pack_chunk();
    put_word(32'd1);
    put_byte(8'hA5);
    put_byte(8'h00);
    emit_chunk(vcsp_pkg::ID_PACK, body_q.size(), 32'd0, -1);
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    emit_chunk(vcsp_pkg::ID_PACK, body_q.size(), 32'hFFFF_FFFF, -1);
  endtask

  // Dimension saturation both ways, extra content, and a cut size list
  task automatic test_size_chunk();
    put_word(32'd0);
    put_word(vcsp_pkg::MAX_DIM);
    put_word(vcsp_pkg::MAX_DIM + 1);
    emit_chunk(vcsp_pkg::ID_SIZE, body_q.size(), 32'd0, -1);
    put_word(32'hFFFF_FFFF);
    put_word(32'h7FFF_FFFF);
    put_word(32'd255);
    repeat (3) put_byte(8'($urandom));
    emit_chunk(vcsp_pkg::ID_SIZE, body_q.size(), 32'd24, -1);
    put_word(32'd1);
    put_word(32'h8000_0000);
    emit_chunk(vcsp_pkg::ID_SIZE, body_q.size(), 32'd0, -1);
  endtask

  task automatic test_voxel_chunk();
    // Corners of the coordinate range, swapped axes visible in the third voxel
    put_word(32'd3);
    put_word(32'h0000_0000);
    put_word(32'hFFFF_FFFF);
    put_word({8'd40, 8'd30, 8'd20, 8'd10});
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // Empty count: bounds at once, the voxel after it is skipped
    put_word(32'd0);
    put_word($urandom);
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // Negative count reads as empty
    put_word(32'hFFFF_FFF0);
    put_word($urandom);
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // More voxels than counted
    put_word(32'd1);
    repeat (3) put_word($urandom);
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // Count past 2^24 saturates; content ends first, bounds at its last byte
    put_word(32'h0100_0001);
    repeat (2) put_word($urandom);
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // Content that holds only the count word
    put_word(32'd5);
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // Count word itself cut short: nothing reported
    put_byte(8'h02);
    put_byte(8'h00);
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
    // Content ends mid-voxel: bounds over the one complete voxel
    put_word(32'd2);
    put_word($urandom);
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, -1);
  endtask

  task automatic test_palette_chunk();
    // Short palette with a partial word at the end
    repeat (3) put_word($urandom);
    repeat (2) put_byte(8'($urandom));
    emit_chunk(vcsp_pkg::ID_RGBA, body_q.size(), 32'd0, -1);
    // Longer palette; the sink holds off for a long stretch while bytes keep
    // coming, so the parser has to stall its input
    for (int k = 0; k < 12; k++)
      put_word(k % 7 == 0 ? 32'hFFFF_FFFF : (k % 11 == 0 ? 32'h0 : $urandom));
    src_steady = 1'b1;
    sink_hold  = 50;
    emit_chunk(vcsp_pkg::ID_RGBA, body_q.size(), 32'd0, -1);
    src_steady = 1'b0;
  endtask

  // Unhandled ids, a one-bit miss of a handled id, and empty contents
  task automatic test_skipped_chunks();
    repeat (6) put_byte(8'($urandom));
    emit_chunk(other_id(), body_q.size(), 32'd0, -1);
    repeat (8) put_byte(8'($urandom));
    emit_chunk(vcsp_pkg::ID_XYZI ^ (32'd1 << $urandom_range(0, 31)),
               body_q.size(), 32'd0, -1);
    emit_chunk(vcsp_pkg::ID_RGBA, 32'd0, 32'd0, -1);
    emit_chunk(vcsp_pkg::ID_SIZE, 32'd0, 32'd0, -1);
    emit_chunk(other_id(), 32'd0, $urandom, -1);
  endtask

  // Mostly well-formed chunks with random content; some cut short or padded
  task automatic test_random_chunks();
    int          first_byte;
    int          pick;
    int          n;
    int          cut;
    logic [31:0] id;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < 48) begin
      src_steady  = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          // Keep the model count at one: any other value ends the file
          id = vcsp_pkg::ID_PACK;
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
          end else begin
            put_word(32'd1);
            repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
          end
        end
        1, 2: begin
          id = vcsp_pkg::ID_SIZE;
          repeat (3) put_word(pick_dim());
        end
        3, 4, 5: begin
          id = vcsp_pkg::ID_XYZI;
          n  = $urandom_range(0, 8);
          case ($urandom_range(0, 5))
            0: put_word(n + $urandom_range(1, 3));
            1: put_word((n > 0) ? n - 1 : 0);
            2: put_word(32'h8000_0000 | n);
            default: put_word(n);
          endcase
          repeat (n) put_word({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
        end
        6, 7: begin
          id = vcsp_pkg::ID_RGBA;
          repeat ($urandom_range(0, 10)) put_word($urandom);
        end
        default: begin
          id = other_id();
          repeat ($urandom_range(0, 8)) put_byte(8'($urandom));
        end
      endcase
      if (pick != 0) begin
        case ($urandom_range(0, 5))
          0: begin
            cut = $urandom_range(0, body_q.size());
            while (body_q.size() > cut) body_q.delete(body_q.size() - 1);
          end
          1: repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
          default: ;
        endcase
      end
      emit_chunk(id, body_q.size(), random_children(), -1);
    end
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  // Close the file one of several ways, picked by the seed
  task automatic test_file_end();
    int pick;
    int n;
    pick = $urandom_range(0, 5);
    case (pick)
      0: send_byte(8'h00, 1'($urandom_range(0, 1)));
      1, 4: begin
        // Last voxel, bounds and the end result all come from one byte; with
        // content left over the end is a truncation
        n = $urandom_range(1, 3);
        put_word(n);
        repeat (n) put_word($urandom);
        if (pick == 4) put_word($urandom);
        emit_chunk(vcsp_pkg::ID_XYZI, body_q.size(), 32'd0, 12 + 4 + 4 * n - 1);
      end
      2: begin
        put_word($urandom_range(0, 1) ? 32'd0 : 32'd2 + $urandom_range(0, 1000));
        repeat (4) put_byte(8'($urandom));
        emit_chunk(vcsp_pkg::ID_PACK, body_q.size(), 32'd0, -1);
      end
      3: begin
        repeat (8) put_byte(8'($urandom));
        emit_chunk(other_id(), body_q.size(), 32'd0, $urandom_range(0, 11));
      end
      default: begin
        // Content size far larger than the file
        repeat (3) put_word($urandom);
        emit_chunk(vcsp_pkg::ID_RGBA, 32'hFFFF_FFF0, 32'd0, 12 + $urandom_range(0, 11));
      end
    endcase
  endtask

  // Bytes after the end are taken and dropped, end mark included
  task automatic test_bytes_after_end();
    repeat (6) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    send_byte(8'h00, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_file_header();
    test_pack_chunk();
    test_size_chunk();
    test_voxel_chunk();
    test_palette_chunk();
    test_skipped_chunks();
    test_random_chunks();
    test_file_end();
    test_bytes_after_end();
    in_valid <= 1'b0;
    // Drain, then give a stray late result time to show up
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_voxel_chunk_stream_parser: clean");
    end else begin
      $display("tb_voxel_chunk_stream_parser: errors");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("tb_voxel_chunk_stream_parser: errors");
    $finish;
  end

endmodule
